### src/sagr_pkg.sv
// Shared types and constants for the scaled alpha glyph renderer.
package sagr_pkg;

  localparam int SCALE_W = 21;
  localparam int RGB_W   = 24;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int NRES    = 3;

  localparam logic [2:0] REG_SCALE_X = 3'd0;
  localparam logic [2:0] REG_SCALE_Y = 3'd1;
  localparam logic [2:0] REG_FORE    = 3'd2;
  localparam logic [2:0] REG_BACK    = 3'd3;
  localparam logic [2:0] REG_BASE    = 3'd4;

  localparam logic OP_HDR    = 1'b0;
  localparam logic OP_PIX    = 1'b1;
  localparam logic KIND_RECT = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  typedef struct packed {
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    logic [RGB_W-1:0]   fore;
    logic [RGB_W-1:0]   back;
    logic [RGB_W-1:0]   base;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [15:0]       w;
    logic [15:0]       h;
    logic [RGB_W-1:0]  color;
    logic [15:0]       fedge;
  } res_t;

  typedef struct packed {
    logic [1:0]           cnt;
    res_t [NRES-1:0]      r;
  } ent_t;

endpackage

### src/sagr_cfg.sv
// APB register file holding scale factors and colors.
module sagr_cfg import sagr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_SCALE_X: cfg_d.sx   = pwdata[SCALE_W-1:0];
        REG_SCALE_Y: cfg_d.sy   = pwdata[SCALE_W-1:0];
        REG_FORE:    cfg_d.fore = pwdata[RGB_W-1:0];
        REG_BACK:    cfg_d.back = pwdata[RGB_W-1:0];
        REG_BASE:    cfg_d.base = pwdata[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCALE_X: prdata = 32'(cfg_q.sx);
      REG_SCALE_Y: prdata = 32'(cfg_q.sy);
      REG_FORE:    prdata = 32'(cfg_q.fore);
      REG_BACK:    prdata = 32'(cfg_q.back);
      REG_BASE:    prdata = 32'(cfg_q.base);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sx   <= SCALE_W'(65536);
      cfg_q.sy   <= SCALE_W'(65536);
      cfg_q.fore <= 24'hFFFFFF;
      cfg_q.back <= '0;
      cfg_q.base <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/sagr_front.sv
// Front end: accepts requests, tracks glyph state and builds result groups.
module sagr_front import sagr_pkg::*; #(
  parameter int MAX_GLYPH_SIDE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] x_offset_i,
  input  logic signed [15:0] y_offset_i,
  input  logic [14:0]        advance_i,
  input  logic [8:0]         box_w_i,
  input  logic [8:0]         box_h_i,
  input  logic [9:0]         line_height_i,
  input  logic signed [15:0] fill_edge_in_i,
  input  logic [7:0]         alpha_i,
  input  logic [QAW:0]       q_free_i,
  output logic               push_o,
  output ent_t               push_ent_o
);

  localparam int CW = $clog2(MAX_GLYPH_SIDE + 1);

  function automatic res_t mk_rect(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                   logic [15:0] h, logic [RGB_W-1:0] c);
    res_t r;
    r.kind  = KIND_RECT;
    r.x     = x;
    r.y     = y;
    r.w     = w;
    r.h     = h;
    r.color = c;
    r.fedge = '0;
    return r;
  endfunction

  // glyph state
  logic signed [15:0] gy_q, dl_q, ys_q, fl_q, fr_q;
  logic [CW-1:0]      gw_q, gh_q, col_q, row_q;

  logic accept, fillbg, stray;
  logic [CW-1:0]      bw_sat, bh_sat;
  logic [CW+20:0]     gwp;
  logic signed [17:0] gwh, l0, lsel, r0, rsel, rx, advs;
  logic [CW:0]        col_inc;

  // stage 1
  logic               s1_v_q, s1_hdr_q;
  logic signed [15:0] s1_gy_q, s1_ys_q, s1_dl_q, s1_fl_q, s1_fr_q, s1_fe_q;
  logic [CW-1:0]      s1_bh_q, s1_col_q, s1_row_q, s1_gw_q;
  logic [9:0]         s1_lh_q;
  logic [7:0]         s1_a_q;

  // stage 2
  logic               s2_v_q, s2_hdr_q;
  logic signed [15:0] s2_gy_q, s2_ys_q, s2_dl_q, s2_fl_q, s2_fr_q, s2_fe_q;
  logic               s2_col0_q;
  logic [7:0]         s2_a_q;
  logic signed [23:0] s2_fa_q, s2_fb_q;
  logic [15:0]        s2_fc_q, s2_fx0_q, s2_fx1_q;
  logic signed [16:0] s2_p_q [3];

  logic signed [17:0] ma, mb;
  logic signed [21:0] sy_s;
  logic signed [39:0] pa, pb;
  logic [31:0]        pc, px0, px1;
  logic signed [16:0] pch [3];
  logic [RGB_W-1:0]   bk;

  assign fillbg  = cfg_i.back != cfg_i.fore;
  assign stray   = (gw_q == '0) || (row_q >= gh_q) || (col_q >= gw_q);
  assign in_stall_o = !(q_free_i > ((QAW+1)'(s1_v_q) + (QAW+1)'(s2_v_q)));
  assign accept  = in_valid_i && !in_stall_o;
  assign col_inc = (CW+1)'(col_q) + (CW+1)'(1);

  always_comb begin
    bw_sat = (32'(box_w_i) > MAX_GLYPH_SIDE) ? CW'(MAX_GLYPH_SIDE) : CW'(box_w_i);
    bh_sat = (32'(box_h_i) > MAX_GLYPH_SIDE) ? CW'(MAX_GLYPH_SIDE) : CW'(box_h_i);
    gwp    = (CW+21)'(bw_sat) * (CW+21)'(cfg_i.sx);
    gwh    = 18'(gwp >> 16);
    advs   = 18'(advance_i);
    l0     = 18'(pos_x_i) + ((x_offset_i < 0) ? 18'(x_offset_i) : 18'sd0);
    lsel   = (l0 < 18'(fill_edge_in_i)) ? 18'(fill_edge_in_i) : l0;
    r0     = gwh + 18'(x_offset_i);
    rsel   = (r0 < advs) ? advs : r0;
    rx     = 18'(pos_x_i) + rsel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gy_q  <= '0;
      dl_q  <= '0;
      ys_q  <= '0;
      fl_q  <= '0;
      fr_q  <= '0;
      gw_q  <= '0;
      gh_q  <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (opcode_i == OP_HDR) begin
        gy_q  <= pos_y_i;
        ys_q  <= y_offset_i;
        dl_q  <= pos_x_i + x_offset_i;
        gw_q  <= bw_sat;
        gh_q  <= bh_sat;
        col_q <= '0;
        row_q <= '0;
        fl_q  <= fillbg ? lsel[15:0] : 16'sd0;
        fr_q  <= fillbg ? rx[15:0] : 16'sd0;
      end else if (!stray) begin
        if (col_inc >= (CW+1)'(gw_q)) begin
          col_q <= '0;
          row_q <= row_q + CW'(1);
        end else begin
          col_q <= col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept && !(opcode_i == OP_PIX && stray);
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hdr_q <= opcode_i == OP_HDR;
      s1_a_q   <= alpha_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_gw_q  <= gw_q;
      s1_dl_q  <= dl_q;
      s1_bh_q  <= bh_sat;
      s1_lh_q  <= line_height_i;
      s1_fe_q  <= fillbg ? rx[15:0] : fill_edge_in_i;
      if (opcode_i == OP_HDR) begin
        s1_gy_q <= pos_y_i;
        s1_ys_q <= y_offset_i;
        s1_fl_q <= lsel[15:0];
        s1_fr_q <= rx[15:0];
      end else begin
        s1_gy_q <= gy_q;
        s1_ys_q <= ys_q;
        s1_fl_q <= fl_q;
        s1_fr_q <= fr_q;
      end
    end
  end

  // stage 1: scaling and blend products
  always_comb begin
    sy_s = 22'(cfg_i.sy);
    bk   = fillbg ? cfg_i.back : cfg_i.base;
    if (s1_hdr_q) begin
      ma = 18'(s1_ys_q);
      mb = 18'(s1_ys_q) + 18'(s1_bh_q);
      pc = 32'(s1_lh_q) * 32'(cfg_i.sy);
    end else begin
      ma = 18'(s1_ys_q) + 18'(s1_row_q);
      mb = 18'(s1_ys_q) + 18'(s1_row_q) + 18'sd1;
      pc = 32'(s1_gw_q) * 32'(cfg_i.sx);
    end
    pa  = 40'(ma) * 40'(sy_s);
    pb  = 40'(mb) * 40'(sy_s);
    px0 = 32'(s1_col_q) * 32'(cfg_i.sx);
    px1 = (32'(s1_col_q) + 32'd1) * 32'(cfg_i.sx);
    for (int c = 0; c < 3; c++) begin
      pch[c] = 17'($signed({1'b0, cfg_i.fore[8*c +: 8]}) - $signed({1'b0, bk[8*c +: 8]}))
             * 17'($signed({1'b0, s1_a_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_hdr_q  <= s1_hdr_q;
      s2_gy_q   <= s1_gy_q;
      s2_ys_q   <= s1_ys_q;
      s2_dl_q   <= s1_dl_q;
      s2_fl_q   <= s1_fl_q;
      s2_fr_q   <= s1_fr_q;
      s2_fe_q   <= s1_fe_q;
      s2_col0_q <= s1_col_q == '0;
      s2_a_q    <= s1_a_q;
      s2_fa_q   <= pa[39:16];
      s2_fb_q   <= pb[39:16];
      s2_fc_q   <= pc[31:16];
      s2_fx0_q  <= px0[31:16];
      s2_fx1_q  <= px1[31:16];
      for (int c = 0; c < 3; c++) s2_p_q[c] <= pch[c];
    end
  end

  // stage 2: result assembly
  always_comb begin
    ent_t               e;
    logic [1:0]         n;
    logic [15:0]        w, h, yr;
    logic signed [23:0] y1;
    logic signed [17:0] dr, v;
    logic [17:0]        mag;
    logic [33:0]        qp;
    logic [7:0]         q;
    logic [RGB_W-1:0]   bkc, col;
    e    = '0;
    n    = '0;
    bkc  = fillbg ? cfg_i.back : cfg_i.base;
    col  = '0;
    w    = s2_fr_q - s2_fl_q;
    y1   = 24'($signed({1'b0, s2_fc_q}));
    dr   = 18'(s2_dl_q) + 18'(s2_fc_q);
    v    = '0;
    mag  = '0;
    qp   = '0;
    q    = '0;
    h    = '0;
    yr   = '0;
    for (int c = 0; c < 3; c++) begin
      v   = 18'(s2_p_q[c]) + 18'sd127;
      mag = v[17] ? 18'(-v) : v;
      qp  = 34'(mag[16:0]) * 34'd32897;
      q   = qp[30:23];
      col[8*c +: 8] = v[17] ? bkc[8*c +: 8] - q : bkc[8*c +: 8] + q;
    end
    if (s2_a_q == 8'd0) col = cfg_i.back;
    else if (s2_a_q == 8'hFF) col = cfg_i.fore;

    if (s2_hdr_q) begin
      if (fillbg && (s2_fl_q < s2_fr_q)) begin
        if (s2_ys_q > 0) begin
          e.r[n] = mk_rect(s2_fl_q, s2_gy_q, w, s2_fa_q[15:0], cfg_i.back);
          n = n + 2'd1;
        end
        if (s2_fb_q < y1) begin
          e.r[n] = mk_rect(s2_fl_q, s2_gy_q + s2_fb_q[15:0], w,
                           16'(y1 - s2_fb_q), cfg_i.back);
          n = n + 2'd1;
        end
      end
      e.r[n]       = '0;
      e.r[n].kind  = KIND_STAT;
      e.r[n].fedge = s2_fe_q;
      n = n + 2'd1;
    end else if (s2_fb_q > s2_fa_q) begin
      h  = 16'(s2_fb_q - s2_fa_q);
      yr = s2_gy_q + s2_fa_q[15:0];
      if (s2_col0_q && fillbg && (s2_fl_q < s2_fr_q)) begin
        if (s2_fl_q < s2_dl_q) begin
          e.r[n] = mk_rect(s2_fl_q, yr, s2_dl_q - s2_fl_q, h, cfg_i.back);
          n = n + 2'd1;
        end
        if (dr < 18'(s2_fr_q)) begin
          e.r[n] = mk_rect(dr[15:0], yr, s2_fr_q - dr[15:0], h, cfg_i.back);
          n = n + 2'd1;
        end
      end
      if ((fillbg || s2_a_q != 8'd0) && (s2_fx1_q > s2_fx0_q)) begin
        e.r[n] = mk_rect(s2_dl_q + s2_fx0_q, yr, s2_fx1_q - s2_fx0_q, h, col);
        n = n + 2'd1;
      end
    end
    e.cnt      = n;
    push_ent_o = e;
    push_o     = s2_v_q && (n != 2'd0);
  end

endmodule

### src/sagr_queue.sv
// Small queue of result groups between front and back end.
module sagr_queue import sagr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ent_t         push_ent_i,
  input  logic         pop_i,
  output logic         nonempty_o,
  output ent_t         head_o,
  output logic [QAW:0] free_o
);

  ent_t           mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;

  assign nonempty_o = cnt_q != '0;
  assign head_o     = mem_q[rp_q];
  assign free_o     = (QAW+1)'(QDEPTH) - cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_ent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QAW'(1);
      if (pop_i)  rp_q <= rp_q + QAW'(1);
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

endmodule

### src/sagr_back.sv
// Back end: walks a result group and drives the output register.
module sagr_back import sagr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  nonempty_i,
  input  ent_t  head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  res_o,
  output logic  last_o
);

  logic [1:0] idx_q;
  logic       v_q, load, fin;
  res_t       res_q;
  logic       last_q;

  assign load        = nonempty_i && (!v_q || !out_stall_i);
  assign fin         = idx_q == head_i.cnt - 2'd1;
  assign pop_o       = load && fin;
  assign out_valid_o = v_q;
  assign res_o       = res_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        v_q   <= 1'b1;
        idx_q <= fin ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.r[idx_q];
      last_q <= fin;
    end
  end

endmodule

### src/scaled_alpha_glyph_renderer.sv
// Top level: scaled alpha glyph renderer.
// A request goes through stage 1, stage 2, the queue and the output register.
// Throughput: one request per cycle when each yields one result and the output is not
// stalled; the back end emits one result per cycle unless out_stall_i holds it.
// Reset: glyph state, queue and output valid clear; registers take default values.
module scaled_alpha_glyph_renderer import sagr_pkg::*; #(
  parameter int MAX_GLYPH_SIDE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] x_offset_i,
  input  logic signed [15:0] y_offset_i,
  input  logic [14:0]        advance_i,
  input  logic [8:0]         box_w_i,
  input  logic [8:0]         box_h_i,
  input  logic [9:0]         line_height_i,
  input  logic signed [15:0] fill_edge_in_i,
  input  logic [7:0]         alpha_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [15:0] rect_x_o,
  output logic signed [15:0] rect_y_o,
  output logic [15:0]        rect_w_o,
  output logic [15:0]        rect_h_o,
  output logic [23:0]        color_rgb_o,
  output logic signed [15:0] fill_edge_out_o,
  output logic               last_o
);

  cfg_t         cfg;
  logic         push, pop, nonempty;
  ent_t         push_ent, head;
  logic [QAW:0] q_free;
  res_t         res;

  sagr_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  sagr_front #(.MAX_GLYPH_SIDE(MAX_GLYPH_SIDE)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_stall_o, .opcode_i, .pos_x_i,
    .pos_y_i, .x_offset_i, .y_offset_i, .advance_i, .box_w_i, .box_h_i,
    .line_height_i, .fill_edge_in_i, .alpha_i, .q_free_i(q_free),
    .push_o(push), .push_ent_o(push_ent)
  );

  sagr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_ent_i(push_ent), .pop_i(pop),
    .nonempty_o(nonempty), .head_o(head), .free_o(q_free)
  );

  sagr_back u_back (
    .clk_i, .rst_ni, .nonempty_i(nonempty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .res_o(res), .last_o
  );

  assign kind_o          = res.kind;
  assign rect_x_o        = res.x;
  assign rect_y_o        = res.y;
  assign rect_w_o        = res.w;
  assign rect_h_o        = res.h;
  assign color_rgb_o     = res.color;
  assign fill_edge_out_o = res.fedge;

endmodule
